// ===== src/alias_table_builder_assert.svh =====
// Assertion macros shared by the alias table builder checkers.
// No dependencies; each file that asserts takes this header by include.
`ifndef ALIAS_TABLE_BUILDER_ASSERT_SVH
`define ALIAS_TABLE_BUILDER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ATB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alias table builder check failed");

// next-cycle implication, disabled while in reset
`define ATB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alias table builder check failed");

// next-cycle implication that also spans reset
`define ATB_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("alias table builder check failed");

`endif

// ===== src/atb_pkg.sv =====
// Types and constants of the alias table builder.
// No dependencies.
`timescale 1ns / 1ps
package atb_pkg;

  localparam int WEIGHT_BITS = 16;
  localparam int ID_BITS     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROB_W      = FRAC_BITS + 1;
  localparam int OP_W        = 4;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [ID_BITS-1:0]     neighbor;
    logic                   last_edge;
  } in_item_t;

  typedef struct packed {
    logic [PROB_W-1:0]  probability;
    logic [ID_BITS-1:0] primary;
    logic [ID_BITS-1:0] alias_res;
    logic               last_slot;
  } out_item_t;

  localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
  localparam logic [OP_W-1:0] OP_RD_W       = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL        = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV        = 4'd4;
  localparam logic [OP_W-1:0] OP_NWR        = 4'd5;
  localparam logic [OP_W-1:0] OP_RD_S       = 4'd6;
  localparam logic [OP_W-1:0] OP_RD_L       = 4'd7;
  localparam logic [OP_W-1:0] OP_LATCH_L    = 4'd8;
  localparam logic [OP_W-1:0] OP_PAIR_EMIT  = 4'd9;
  localparam logic [OP_W-1:0] OP_RD_NB      = 4'd10;
  localparam logic [OP_W-1:0] OP_LATCH_NB   = 4'd11;
  localparam logic [OP_W-1:0] OP_LEFT_EMIT  = 4'd12;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic last_load;
    logic div_done;
    logic norm_last;
    logic sq_ne;
    logic lq_ne;
    logic out_free;
    logic final_slot;
  } sts_t;

endpackage

// ===== src/atb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module atb_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/atb_ctrl.sv =====
// Sequencer of the alias table builder: load, normalize, pair, drain.
// Depends on atb_pkg.
`timescale 1ns / 1ps
module atb_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  atb_pkg::sts_t sts,
  output atb_pkg::cmd_t cmd
);
  import atb_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NRD  = 4'd1;
  localparam logic [3:0] S_NMUL = 4'd2;
  localparam logic [3:0] S_NDIV = 4'd3;
  localparam logic [3:0] S_NWR  = 4'd4;
  localparam logic [3:0] S_PCHK = 4'd5;
  localparam logic [3:0] S_PIDX = 4'd6;
  localparam logic [3:0] S_PS   = 4'd7;
  localparam logic [3:0] S_PL   = 4'd8;
  localparam logic [3:0] S_PEM  = 4'd9;
  localparam logic [3:0] S_LIDX = 4'd10;
  localparam logic [3:0] S_LNB  = 4'd11;
  localparam logic [3:0] S_LEM  = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        cmd.op = OP_LOAD;
        if (sts.last_load) state_nxt = S_NRD;
      end
      S_NRD: begin
        cmd.op    = OP_RD_W;
        state_nxt = S_NMUL;
      end
      S_NMUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_NDIV;
      end
      S_NDIV: begin
        cmd.op = OP_DIV;
        if (sts.div_done) state_nxt = S_NWR;
      end
      S_NWR: begin
        cmd.op    = OP_NWR;
        state_nxt = sts.norm_last ? S_PCHK : S_NRD;
      end
      S_PCHK: begin
        priority if (sts.sq_ne && sts.lq_ne) begin
          state_nxt = S_PIDX;
        end else if (sts.sq_ne || sts.lq_ne) begin
          state_nxt = S_LIDX;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PIDX: begin
        cmd.op    = OP_RD_S;
        state_nxt = S_PS;
      end
      S_PS: begin
        cmd.op    = OP_RD_L;
        state_nxt = S_PL;
      end
      S_PL: begin
        cmd.op    = OP_LATCH_L;
        state_nxt = S_PEM;
      end
      S_PEM: begin
        if (sts.out_free) begin
          cmd.op    = OP_PAIR_EMIT;
          state_nxt = sts.final_slot ? S_IDLE : S_PCHK;
        end
      end
      S_LIDX: begin
        cmd.op    = OP_RD_NB;
        state_nxt = S_LNB;
      end
      S_LNB: begin
        cmd.op    = OP_LATCH_NB;
        state_nxt = S_LEM;
      end
      S_LEM: begin
        if (sts.out_free) begin
          cmd.op    = OP_LEFT_EMIT;
          state_nxt = sts.final_slot ? S_IDLE : S_PCHK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/atb_dp.sv =====
// Datapath of the alias table builder: edge stores, queues, divider, output register.
// Depends on atb_pkg and atb_ram.
`timescale 1ns / 1ps
module atb_dp #(
  parameter int MAX_DEG = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  atb_pkg::cmd_t      cmd,
  output atb_pkg::sts_t      sts,
  input  logic               in_valid,
  output logic               in_ready,
  input  atb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output atb_pkg::out_item_t out_data
);
  import atb_pkg::*;

  localparam int IDX_W  = (MAX_DEG > 1) ? $clog2(MAX_DEG) : 1;
  localparam int CNT_W  = $clog2(MAX_DEG + 1);
  localparam int TOT_W  = WEIGHT_BITS + IDX_W;
  localparam int SC_W   = FRAC_BITS + CNT_W;
  localparam int PROD_W = WEIGHT_BITS + CNT_W;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int DC_W   = $clog2(NUM_W);
  localparam int SQ_D   = 2 * MAX_DEG;
  localparam int SQA_W  = $clog2(SQ_D);
  localparam int SQP_W  = $clog2(SQ_D + 1);
  localparam logic [SC_W-1:0] ONE_SC = SC_W'(1) << FRAC_BITS;

  logic [CNT_W-1:0] edge_cnt_r, j_r, lhead_r, ltail_r, emit_cnt_r;
  logic [TOT_W-1:0] total_r, rem_r;
  logic [NUM_W-1:0] num_r;
  logic [SC_W-1:0]  q_r, sval_r, lval_r;
  logic [DC_W-1:0]  dcnt_r;
  logic [SQP_W-1:0] shead_r, stail_r;
  logic [IDX_W-1:0] l_idx_r;
  logic [ID_BITS-1:0] nbs_r, nbl_r;
  logic small_sel_r, out_valid_r;
  out_item_t out_data_r;

  logic             sw_we, nb_we, sq_we, lq_we;
  logic [IDX_W-1:0] sw_waddr, sw_raddr, nb_raddr, lq_waddr;
  logic [SC_W-1:0]  sw_wdata, sw_rdata;
  logic [ID_BITS-1:0] nb_rdata;
  logic [SQA_W-1:0] sq_waddr;
  logic [IDX_W-1:0] sq_wdata, sq_rdata, lq_rdata;

  logic in_fire, load_store, sq_ne, lq_ne, out_free, final_slot, emit;
  logic [TOT_W:0]   r2, diff;
  logic             ge, small_q, l_small;
  logic [SC_W-1:0]  nrm_val, new_l;
  logic [SC_W:0]    sum;
  logic [IDX_W-1:0] lo_idx;
  logic [PROD_W-1:0] mul_w;
  logic [CNT_W-1:0] n_m1;

  assign in_ready   = (cmd.op == OP_LOAD);
  assign in_fire    = in_valid && in_ready;
  assign load_store = in_fire && (edge_cnt_r < CNT_W'(MAX_DEG));
  assign sq_ne      = (shead_r != stail_r);
  assign lq_ne      = (lhead_r != ltail_r);
  assign out_free   = !out_valid_r || out_ready;
  assign n_m1       = edge_cnt_r - CNT_W'(1);
  assign final_slot = (emit_cnt_r == n_m1);
  assign emit       = (cmd.op == OP_PAIR_EMIT) || (cmd.op == OP_LEFT_EMIT);

  assign r2      = {rem_r, num_r[NUM_W-1]};
  assign ge      = (r2 >= {1'b0, total_r});
  assign diff    = r2 - {1'b0, total_r};
  assign small_q = (total_r != '0) && (q_r < ONE_SC);
  assign nrm_val = (total_r == '0) ? '0 : q_r;
  assign sum     = {1'b0, sval_r} + {1'b0, lval_r};
  assign new_l   = (sum >= {1'b0, ONE_SC}) ? SC_W'(sum - {1'b0, ONE_SC}) : '0;
  assign l_small = (new_l < ONE_SC);
  assign lo_idx  = sq_ne ? sq_rdata : lq_rdata;
  assign mul_w   = PROD_W'(sw_rdata[WEIGHT_BITS-1:0]) * PROD_W'(edge_cnt_r);

  always_comb begin
    sw_we    = 1'b0;
    sw_waddr = j_r[IDX_W-1:0];
    sw_wdata = nrm_val;
    sw_raddr = j_r[IDX_W-1:0];
    nb_raddr = l_idx_r;
    sq_we    = 1'b0;
    sq_waddr = stail_r[SQA_W-1:0];
    sq_wdata = j_r[IDX_W-1:0];
    lq_we    = 1'b0;
    lq_waddr = ltail_r[IDX_W-1:0];
    unique case (cmd.op)
      OP_LOAD: begin
        sw_we    = load_store;
        sw_waddr = edge_cnt_r[IDX_W-1:0];
        sw_wdata = SC_W'(in_data.weight);
      end
      OP_NWR: begin
        sw_we = 1'b1;
        sq_we = small_q;
        lq_we = !small_q;
      end
      OP_RD_S: begin
        sw_raddr = sq_rdata;
        nb_raddr = sq_rdata;
      end
      OP_RD_L: begin
        sw_raddr = l_idx_r;
      end
      OP_PAIR_EMIT: begin
        sw_we    = 1'b1;
        sw_waddr = l_idx_r;
        sw_wdata = new_l;
        sq_we    = l_small;
        sq_wdata = l_idx_r;
      end
      OP_RD_NB: begin
        nb_raddr = lo_idx;
      end
      default: begin
      end
    endcase
  end

  assign nb_we = load_store;

  atb_ram #(.W(SC_W), .DEPTH(MAX_DEG)) u_sw_ram (
    .clk(clk), .we(sw_we), .waddr(sw_waddr), .wdata(sw_wdata),
    .raddr(sw_raddr), .rdata(sw_rdata)
  );

  atb_ram #(.W(ID_BITS), .DEPTH(MAX_DEG)) u_nb_ram (
    .clk(clk), .we(nb_we), .waddr(edge_cnt_r[IDX_W-1:0]), .wdata(in_data.neighbor),
    .raddr(nb_raddr), .rdata(nb_rdata)
  );

  atb_ram #(.W(IDX_W), .DEPTH(SQ_D)) u_sq_ram (
    .clk(clk), .we(sq_we), .waddr(sq_waddr), .wdata(sq_wdata),
    .raddr(shead_r[SQA_W-1:0]), .rdata(sq_rdata)
  );

  atb_ram #(.W(IDX_W), .DEPTH(MAX_DEG)) u_lq_ram (
    .clk(clk), .we(lq_we), .waddr(lq_waddr), .wdata(j_r[IDX_W-1:0]),
    .raddr(lhead_r[IDX_W-1:0]), .rdata(lq_rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_MUL: begin
        num_r  <= {mul_w, {FRAC_BITS{1'b0}}};
        rem_r  <= '0;
      end
      OP_DIV: begin
        num_r <= num_r << 1;
        rem_r <= ge ? diff[TOT_W-1:0] : r2[TOT_W-1:0];
        q_r   <= {q_r[SC_W-2:0], ge};
      end
      OP_RD_S:     l_idx_r <= lq_rdata;
      OP_RD_L: begin
        sval_r <= sw_rdata;
        nbs_r  <= nb_rdata;
      end
      OP_LATCH_L: begin
        lval_r <= sw_rdata;
        nbl_r  <= nb_rdata;
      end
      OP_LATCH_NB: nbs_r <= nb_rdata;
      default: begin
      end
    endcase
    if (cmd.op == OP_PAIR_EMIT) begin
      out_data_r.probability <= PROB_W'(sval_r);
      out_data_r.primary     <= nbs_r;
      out_data_r.alias_res   <= nbl_r;
      out_data_r.last_slot   <= final_slot;
    end else if (cmd.op == OP_LEFT_EMIT) begin
      out_data_r.probability <= PROB_W'(ONE_SC);
      out_data_r.primary     <= nbs_r;
      out_data_r.alias_res   <= nbs_r;
      out_data_r.last_slot   <= final_slot;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_cnt_r  <= '0;
      total_r     <= '0;
      j_r         <= '0;
      dcnt_r      <= '0;
      shead_r     <= '0;
      stail_r     <= '0;
      lhead_r     <= '0;
      ltail_r     <= '0;
      emit_cnt_r  <= '0;
      small_sel_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          if (load_store) begin
            edge_cnt_r <= edge_cnt_r + CNT_W'(1);
            total_r    <= total_r + TOT_W'(in_data.weight);
          end
          if (in_fire && in_data.last_edge) begin
            j_r        <= '0;
            shead_r    <= '0;
            stail_r    <= '0;
            lhead_r    <= '0;
            ltail_r    <= '0;
            emit_cnt_r <= '0;
          end
        end
        OP_MUL: dcnt_r <= '0;
        OP_DIV: dcnt_r <= dcnt_r + DC_W'(1);
        OP_NWR: begin
          j_r <= j_r + CNT_W'(1);
          if (small_q) begin
            stail_r <= stail_r + SQP_W'(1);
          end else begin
            ltail_r <= ltail_r + CNT_W'(1);
          end
        end
        OP_PAIR_EMIT: begin
          shead_r    <= shead_r + SQP_W'(1);
          emit_cnt_r <= emit_cnt_r + CNT_W'(1);
          if (l_small) begin
            lhead_r <= lhead_r + CNT_W'(1);
            stail_r <= stail_r + SQP_W'(1);
          end
          if (final_slot) begin
            edge_cnt_r <= '0;
            total_r    <= '0;
          end
        end
        OP_RD_NB: small_sel_r <= sq_ne;
        OP_LEFT_EMIT: begin
          emit_cnt_r <= emit_cnt_r + CNT_W'(1);
          if (small_sel_r) begin
            shead_r <= shead_r + SQP_W'(1);
          end else begin
            lhead_r <= lhead_r + CNT_W'(1);
          end
          if (final_slot) begin
            edge_cnt_r <= '0;
            total_r    <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign sts.last_load  = in_fire && in_data.last_edge;
  assign sts.div_done   = (dcnt_r == DC_W'(NUM_W - 1));
  assign sts.norm_last  = (j_r == n_m1);
  assign sts.sq_ne      = sq_ne;
  assign sts.lq_ne      = lq_ne;
  assign sts.out_free   = out_free;
  assign sts.final_slot = final_slot;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/alias_table_builder.sv =====
// Top level of the alias table builder: sequencer plus datapath.
// Depends on atb_pkg, atb_ctrl, atb_dp.
//
// Usage: edges enter on the in_ channel (valid/ready), one request per cycle
// while the block is loading. The request with last_edge set closes the vertex
// and starts the build; in_ready stays low until the last slot is loaded into
// the output register. Edges past MAX_DEG are dropped, the closing one still
// starts the build.
// Normalization of each edge is one read, one multiply, 39 steps of the
// restoring divider and one write back; the divider loop sets the rate.
// Pairing then steps each slot through queue check, small read, large read,
// large latch and emit, a leftover slot through queue check, neighbor read,
// latch and emit, plus stalls on out_ready.
// Results leave on the out_ channel from an output register; a stalled
// receiver holds the sequencer at its emit step, nothing is lost.
// Reset (rst_n low, synchronous) empties the edge count, sum, queues and the
// output register; the edge stores need no clearing.
`timescale 1ns / 1ps
module alias_table_builder #(
  parameter int MAX_DEG = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  atb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output atb_pkg::out_item_t out_data
);
  import atb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  atb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .sts(sts), .cmd(cmd)
  );

  atb_dp #(.MAX_DEG(MAX_DEG)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

// ===== src/atb_chk.sv =====
// Port-level checker of the alias table builder, bound to the top level.
// Depends on atb_pkg and alias_table_builder_assert.svh.
`timescale 1ns / 1ps
`include "alias_table_builder_assert.svh"
module atb_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input atb_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input atb_pkg::out_item_t out_data
);
  import atb_pkg::*;

  `ATB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ATB_ASSERT_RST(a_rst_clear, !rst_n, !out_valid)
  `ATB_ASSERT_NOW(a_busy_mid_table, out_valid && !out_data.last_slot, !in_ready)
  `ATB_ASSERT_NEXT(a_build_starts, in_valid && in_ready && in_data.last_edge, !in_ready)

endmodule

bind alias_table_builder atb_chk u_chk (.*);

// ===== tb/alias_checker.sv =====
// Checker for the alias table builder: watches both channels, predicts slots.
// Depends on atb_pkg; instantiated by the testbench top beside the block.
`timescale 1ns / 1ps
module alias_checker #(
  parameter int MAX_DEG = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  atb_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  atb_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_slots
);
  import atb_pkg::*;

  localparam logic [23:0] ONE_Q = 24'd1 << FRAC_BITS;

  logic [63:0]        edge_weight [MAX_DEG];
  logic [ID_BITS-1:0] edge_nb [MAX_DEG];
  int                 n_edges;
  logic [63:0]        total_w;
  out_item_t          slot_q[$];

  initial pending_slots = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("slot %s: got %0h want %0h", what, got, want);
    fail_count++;
  endtask

  task automatic push_slot(input logic [63:0] p, input logic [ID_BITS-1:0] a,
                           input logic [ID_BITS-1:0] b);
    out_item_t s;
    s.probability = p[PROB_W-1:0];
    s.primary = a;
    s.alias_res = b;
    s.last_slot = 1'b0;
    slot_q.push_back(s);
  endtask

  task automatic build_table();
    int sq[$];
    int lq[$];
    int s, l;
    logic [63:0] sum;
    logic [63:0] scaled [MAX_DEG];
    for (int j = 0; j < n_edges; j++) begin
      scaled[j] = 64'd0;
      if (total_w != 0) scaled[j] = ((edge_weight[j] * 64'(n_edges)) << FRAC_BITS) / total_w;
      if (total_w != 0 && scaled[j] < 64'(ONE_Q)) sq.push_back(j);
      else lq.push_back(j);
    end
    while (sq.size() > 0 && lq.size() > 0) begin
      s = sq.pop_front();
      l = lq[0];
      push_slot(scaled[s], edge_nb[s], edge_nb[l]);
      sum = scaled[l] + scaled[s];
      scaled[l] = (sum >= 64'(ONE_Q)) ? sum - 64'(ONE_Q) : 64'd0;
      if (scaled[l] < 64'(ONE_Q)) begin
        void'(lq.pop_front());
        sq.push_back(l);
      end
    end
    foreach (sq[i]) push_slot(64'(ONE_Q), edge_nb[sq[i]], edge_nb[sq[i]]);
    foreach (lq[i]) push_slot(64'(ONE_Q), edge_nb[lq[i]], edge_nb[lq[i]]);
    if (slot_q.size() > 0) slot_q[$].last_slot = 1'b1;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      n_edges = 0;
      total_w = 64'd0;
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (n_edges < MAX_DEG) begin
          edge_weight[n_edges] = 64'(in_data.weight);
          edge_nb[n_edges] = in_data.neighbor;
          total_w = total_w + 64'(in_data.weight);
          n_edges = n_edges + 1;
        end
        if (in_data.last_edge) begin
          build_table();
          n_edges = 0;
          total_w = 64'd0;
        end
      end
      if (out_valid && out_ready) begin
        if (slot_q.size() == 0) begin
          report("unexpected", 64'(out_data.primary), 64'd0);
        end else begin
          want = slot_q.pop_front();
          if (out_data.probability !== want.probability)
            report("probability", 64'(out_data.probability), 64'(want.probability));
          if (out_data.primary !== want.primary)
            report("primary", 64'(out_data.primary), 64'(want.primary));
          if (out_data.alias_res !== want.alias_res)
            report("alias_res", 64'(out_data.alias_res), 64'(want.alias_res));
          if (out_data.last_slot !== want.last_slot)
            report("last_slot", 64'(out_data.last_slot), 64'(want.last_slot));
        end
      end
    end
    pending_slots = slot_q.size();
  end
endmodule

// ===== tb/testbench.sv =====
// Testbench top for the alias table builder: drives edge requests, stalls the
// receiver, gives the verdict. Depends on atb_pkg, alias_table_builder, alias_checker.
`timescale 1ns / 1ps
module testbench;
  import atb_pkg::*;

  localparam int  MAX_DEG = 64;
  localparam longint LIMIT = 2000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending_slots;
  longint    cycle = 0;
  bit        hold_out = 1'b0;
  bit        stall_on = 1'b1;

  always #5 clk = ~clk;

  alias_table_builder #(.MAX_DEG(MAX_DEG)) DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  alias_checker #(.MAX_DEG(MAX_DEG)) u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .fail_count(fail_count), .pending_slots(pending_slots)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("alias_table_builder: mismatch");
      $finish;
    end
  end

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
      end else if (!stall_on || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        n = gap_len();
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_edge(input logic [15:0] w, input logic [31:0] nb, input bit last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{weight: w, neighbor: nb, last_edge: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vertex(input int deg, input int kind);
    logic [15:0] w;
    for (int i = 0; i < deg; i++) begin
      case (kind)
        1: w = 16'd0;
        2: w = 16'hFFFF;
        3: w = (i == 0) ? 16'hFFFF : 16'd1;
        default: w = rand_weight();
      endcase
      send_edge(w, $urandom, i == deg - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_slots != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int d;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_edge(16'd5, 32'hFFFF_FFFF, 1'b1);
    send_vertex(4, 1);
    send_vertex(4, 2);
    send_vertex(5, 3);
    send_edge(16'd0, 32'h0, 1'b0);
    send_edge(16'hFFFF, 32'h1234_5678, 1'b1);
    drain();
    sent = 0;
    stall_on = 1'b0;
    send_vertex(70, 0);
    drain();
    stall_on = 1'b1;
    hold_out = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_out = 1'b0;
      end
      begin
        send_vertex(3, 0);
        send_vertex(3, 0);
        send_vertex(2, 0);
      end
    join
    drain();
    while (sent < 330) begin
      d = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      send_vertex(d, ($urandom_range(0, 15) == 0) ? $urandom_range(1, 3) : 0);
      sent += d;
      if ($urandom_range(0, 5) == 0) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_slots == 0) begin
      $display("alias_table_builder: match");
    end else begin
      $display("alias_table_builder: mismatch");
    end
    $finish;
  end
endmodule
